@@ src/euler_normal_matrix_unit_macros.svh @@
// Assertion macros used by the checker of this block.
`ifndef EULER_NORMAL_MATRIX_UNIT_MACROS_SVH
`define EULER_NORMAL_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define ENM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define ENM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define ENM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/enm_pkg.sv @@
package enm_pkg;

    // Entry lanes and rows of the matrix
    localparam int LANES     = 9;
    localparam int ROWS      = 3;
    localparam int ROW_LANES = 3;

    // Datapath widths
    localparam int ANG_W  = 16;
    localparam int TRIG_W = 16;
    localparam int PAIR_W = 32;
    localparam int NUM_W  = 48;
    localparam int DIV_W  = 16;
    localparam int DVD_W  = 30;
    localparam int OUT_W  = 32;

    // Numerator is divided by scale * 2^18: drop these bits first
    localparam int NUM_SHIFT = 18;

    // One division cell per quotient bit
    localparam int DIV_CELLS = DVD_W;

    // Sine polynomial coefficients, Q14
    localparam logic [10:0] POLY_C   = 11'd1160;
    localparam logic [13:0] POLY_B   = 14'd10512;
    localparam logic [14:0] POLY_A   = 15'd25736;
    localparam logic [14:0] TRIG_ONE = 15'd16384;

    // Word that moves along the divider chain
    typedef struct packed {
        logic [LANES-1:0][DVD_W-1:0] dq;    // dividend bits shifting out, quotient in
        logic [LANES-1:0][DIV_W-1:0] rem;   // partial remainder
        logic [ROWS-1:0][DIV_W-1:0]  dvsr;  // divisor magnitude per row
        logic [LANES-1:0]            neg;   // result sign per entry
        logic [ROWS-1:0]             zero;  // zero scale per row
    } t_div_word;

endpackage

@@ src/enm_sin.sv @@
module enm_sin (
    input  logic                        i_clk,
    input  logic [3:0]                  i_en,
    input  logic [enm_pkg::ANG_W-1:0]   i_angle,
    output logic signed [enm_pkg::TRIG_W-1:0] o_sin
);
    import enm_pkg::*;

    logic [14:0] z;
    logic [29:0] zz;
    logic [25:0] p1;
    logic [28:0] p2;
    logic [29:0] p3;
    logic [15:0] mag;

    logic [14:0] r_z1, r_z2, r_z3;
    logic [14:0] r_sq1, r_sq2;
    logic [13:0] r_t2;
    logic [14:0] r_t3;
    logic        r_neg1, r_neg2, r_neg3;
    logic signed [TRIG_W-1:0] r_sin;

    // Fold the angle into the first quadrant and square it
    always_comb begin
        z   = i_angle[14] ? 15'(TRIG_ONE - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
        zz  = z * z;
        p1  = POLY_C * r_sq1;
        p2  = r_t2 * r_sq2;
        p3  = r_t3 * r_z3;
        mag = p3[29:14];
    end

    // Stage 1: z and z^2
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_z1   <= z;
            r_sq1  <= zz[28:14];
            r_neg1 <= i_angle[15];
        end
    end

    // Stage 2: inner polynomial term
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_z2   <= r_z1;
            r_sq2  <= r_sq1;
            r_t2   <= 14'(POLY_B - 14'(p1[25:14]));
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: outer polynomial term
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_z3   <= r_z2;
            r_t3   <= 15'(POLY_A - 15'(p2[28:14]));
            r_neg3 <= r_neg2;
        end
    end

    // Stage 4: final product and sign
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_sin <= r_neg3 ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_sin = r_sin;

endmodule

@@ src/enm_div_cell.sv @@
module enm_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  enm_pkg::t_div_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output enm_pkg::t_div_word  o_word
);
    import enm_pkg::*;

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;
    logic [DIV_W:0] shifted [LANES];
    logic [DIV_W:0] diff    [LANES];

    // One restoring step per lane: shift in a dividend bit, try the subtract
    always_comb begin
        n_word = i_word;
        for (int k = 0; k < LANES; k++) begin
            shifted[k] = {i_word.rem[k], i_word.dq[k][DVD_W-1]};
            diff[k]    = shifted[k] - {1'b0, i_word.dvsr[k / ROW_LANES]};
            if (shifted[k] >= {1'b0, i_word.dvsr[k / ROW_LANES]}) begin
                n_word.rem[k] = diff[k][DIV_W-1:0];
                n_word.dq[k]  = {i_word.dq[k][DVD_W-2:0], 1'b1};
            end else begin
                n_word.rem[k] = shifted[k][DIV_W-1:0];
                n_word.dq[k]  = {i_word.dq[k][DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Advance when the next cell takes our word or we hold none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ src/euler_normal_matrix_unit.sv @@
// Scaled YXZ Euler rotation matrix, streaming.
// Slave channel: one word carries three binary angles and three Q8.8 scales.
// Master channel: one word carries the nine Q16.16 entries, row by row, and
// tuser holds one zero-scale flag per row; a flagged row reads as zeros.
// From input accept to output valid a word passes the sine/cosine pipelines,
// the stages for products, sums and sign removal, the divider chain (one
// quotient bit per cell) and the output register.
// Throughput: one word per cycle when not stalled; the divider chain has 30
// cells, each cell shifting all nine lanes in step.
// Reset clears every stage's valid bit; payload registers are not cleared.
// When the receiver stalls, the output word holds and each stage keeps
// filling empty slots behind it, so input stays ready until the pipeline
// is full; o_s_axis_tready is then low until the receiver takes a word.
module euler_normal_matrix_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z (16 bits each)
    input  logic [95:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
    output logic [287:0] o_m_axis_tdata,
    // zero_scale (3 bits)
    output logic [2:0]   o_m_axis_tuser
);
    import enm_pkg::*;

    localparam int FRONT = 8;

    logic [FRONT-1:0] r_v;
    logic [FRONT-1:0] ld;

    logic [ROWS-1:0][DIV_W-1:0] r_sc [7];

    logic signed [TRIG_W-1:0] c1, s1, c2, s2, c3, s3;

    // Pairwise products, stage 5
    logic signed [PAIR_W-1:0] r_c1c3, r_s1s2, r_c2s3, r_c1s2, r_c3s1;
    logic signed [PAIR_W-1:0] r_c1s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    logic signed [TRIG_W-1:0] r_s2_5, r_s3_5, r_c3_5;

    // Triple products and carried pairs, stage 6
    logic signed [NUM_W-1:0]  r_t00, r_t02, r_t10, r_t12;
    logic signed [PAIR_W-1:0] r_p_c1c3, r_p_c3s1, r_p_c1s3, r_p_s1s3;
    logic signed [PAIR_W-1:0] r_p_c2s3, r_p_c2c3, r_p_c2s1, r_p_c1c2;
    logic signed [TRIG_W-1:0] r_s2_6;

    // Numerators, stage 7
    logic signed [NUM_W-1:0] r_num [LANES];
    logic signed [NUM_W-1:0] n_num [LANES];

    // Divider entry word, stage 8
    t_div_word r_dw, n_dw;
    logic [NUM_W-1:0] mag [LANES];

    t_div_word w   [DIV_CELLS+1];
    logic      v   [DIV_CELLS+1];
    logic      rdy [DIV_CELLS+1];

    logic         r_out_valid;
    logic [287:0] r_out_data;
    logic [2:0]   r_out_user;
    logic [287:0] n_out_data;
    logic [OUT_W-1:0] qv [LANES];

    // Ready runs back from the output: a stage loads when empty or draining
    always_comb begin
        ld[FRONT-1] = !r_v[FRONT-1] || rdy[0];
        for (int k = FRONT - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign o_s_axis_tready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < FRONT; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Carry the scales alongside the trig pipelines
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_sc[0] <= i_s_axis_tdata[95:48];
        end
        for (int k = 1; k < 7; k++) begin
            if (ld[k]) begin
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    // Sines and cosines: angle 1 is Y, 2 is X, 3 is Z
    enm_sin u_sin_x (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(i_s_axis_tdata[15:0]), .o_sin(s2));
    enm_sin u_cos_x (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(16'(i_s_axis_tdata[15:0] + 16'h4000)), .o_sin(c2));
    enm_sin u_sin_y (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(i_s_axis_tdata[31:16]), .o_sin(s1));
    enm_sin u_cos_y (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(16'(i_s_axis_tdata[31:16] + 16'h4000)), .o_sin(c1));
    enm_sin u_sin_z (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(i_s_axis_tdata[47:32]), .o_sin(s3));
    enm_sin u_cos_z (.i_clk(i_clk), .i_en(ld[3:0]),
                     .i_angle(16'(i_s_axis_tdata[47:32] + 16'h4000)), .o_sin(c3));

    // Stage 5: products of two trig values
    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_c1c3 <= c1 * c3;
            r_s1s2 <= s1 * s2;
            r_c2s3 <= c2 * s3;
            r_c1s2 <= c1 * s2;
            r_c3s1 <= c3 * s1;
            r_c1s3 <= c1 * s3;
            r_c2c3 <= c2 * c3;
            r_s1s3 <= s1 * s3;
            r_c2s1 <= c2 * s1;
            r_c1c2 <= c1 * c2;
            r_s2_5 <= s2;
            r_s3_5 <= s3;
            r_c3_5 <= c3;
        end
    end

    // Stage 6: products of three trig values
    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_t00    <= r_s1s2 * r_s3_5;
            r_t02    <= r_c1s2 * r_s3_5;
            r_t10    <= r_s1s2 * r_c3_5;
            r_t12    <= r_c1c3 * r_s2_5;
            r_p_c1c3 <= r_c1c3;
            r_p_c3s1 <= r_c3s1;
            r_p_c1s3 <= r_c1s3;
            r_p_s1s3 <= r_s1s3;
            r_p_c2s3 <= r_c2s3;
            r_p_c2c3 <= r_c2c3;
            r_p_c2s1 <= r_c2s1;
            r_p_c1c2 <= r_c1c2;
            r_s2_6   <= r_s2_5;
        end
    end

    // Stage 7: numerators in Q42
    always_comb begin
        n_num[0] = $signed({{2{r_p_c1c3[31]}}, r_p_c1c3, 14'b0}) + r_t00;
        n_num[1] = $signed({{2{r_p_c2s3[31]}}, r_p_c2s3, 14'b0});
        n_num[2] = r_t02 - $signed({{2{r_p_c3s1[31]}}, r_p_c3s1, 14'b0});
        n_num[3] = r_t10 - $signed({{2{r_p_c1s3[31]}}, r_p_c1s3, 14'b0});
        n_num[4] = $signed({{2{r_p_c2c3[31]}}, r_p_c2c3, 14'b0});
        n_num[5] = r_t12 + $signed({{2{r_p_s1s3[31]}}, r_p_s1s3, 14'b0});
        n_num[6] = $signed({{2{r_p_c2s1[31]}}, r_p_c2s1, 14'b0});
        n_num[7] = -$signed({{4{r_s2_6[15]}}, r_s2_6, 28'b0});
        n_num[8] = $signed({{2{r_p_c1c2[31]}}, r_p_c1c2, 14'b0});
    end

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_num <= n_num;
        end
    end

    // Stage 8: strip signs, pre-shift the dividend, set up the divider word
    always_comb begin
        n_dw = '0;
        for (int r = 0; r < ROWS; r++) begin
            n_dw.dvsr[r] = r_sc[6][r][DIV_W-1] ? 16'(-r_sc[6][r]) : r_sc[6][r];
            n_dw.zero[r] = (r_sc[6][r] == '0);
        end
        for (int k = 0; k < LANES; k++) begin
            mag[k]       = r_num[k][NUM_W-1] ? NUM_W'(-r_num[k]) : NUM_W'(r_num[k]);
            n_dw.dq[k]   = mag[k][NUM_SHIFT +: DVD_W];
            n_dw.neg[k]  = r_num[k][NUM_W-1] ^ r_sc[6][k / ROW_LANES][DIV_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[7]) begin
            r_dw <= n_dw;
        end
    end

    // Divider chain: one quotient bit per cell
    assign w[0] = r_dw;
    assign v[0] = r_v[FRONT-1];
    assign rdy[DIV_CELLS] = !r_out_valid || i_m_axis_tready;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        enm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[j]),
            .o_ready (rdy[j]),
            .i_word  (w[j]),
            .o_valid (v[j+1]),
            .i_ready (rdy[j+1]),
            .o_word  (w[j+1])
        );
    end

    // Restore signs and zero flagged rows
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            qv[k] = w[DIV_CELLS].neg[k] ? OUT_W'(-{2'b0, w[DIV_CELLS].dq[k]})
                                        : {2'b0, w[DIV_CELLS].dq[k]};
            if (w[DIV_CELLS].zero[k / ROW_LANES]) begin
                qv[k] = '0;
            end
            n_out_data[k*OUT_W +: OUT_W] = qv[k];
        end
    end

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy[DIV_CELLS]) begin
            r_out_valid <= v[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[DIV_CELLS]) begin
            r_out_data <= n_out_data;
            r_out_user <= w[DIV_CELLS].zero;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

@@ src/enm_chk.sv @@
`include "euler_normal_matrix_unit_macros.svh"

module enm_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [95:0]  i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [287:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser
);

    // Reset empties the output
    `ENM_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")

    // A stalled word holds
    `ENM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled output word changed")

    // Row 0 reads as zero when its zero-scale flag is set
    `ENM_ASSERT_IMPLY(a_zero_row0, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[95:0] == 96'd0, "row 0 not zero with flag")

    // An empty output leaves the input side ready
    `ENM_ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input blocked with empty output")

endmodule

bind euler_normal_matrix_unit enm_chk u_enm_chk (.*);
